/* rtl/dupd_pkg.sv */
// shared types, constants and character decode functions for the data URI decoder
`default_nettype none

package dupd_pkg;

	// character codes
	localparam logic [7:0] CH_COMMA   = 8'h2c;
	localparam logic [7:0] CH_SEMI    = 8'h3b;
	localparam logic [7:0] CH_PERCENT = 8'h25;
	localparam logic [7:0] CH_EQUALS  = 8'h3d;
	localparam logic [7:0] CH_PLUS    = 8'h2b;
	localparam logic [7:0] CH_SLASH   = 8'h2f;

	// length of the ";base64" tag
	localparam logic [2:0] TAG_LEN = 3'd7;

	// decode results that mean "not a digit"
	localparam logic [4:0] HEX_NONE = 5'd16;
	localparam logic [6:0] B64_NONE = 7'd64;

	// bundle queue between front and back
	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);

	// up to three bytes caused by one item, plus the end flag
	typedef struct packed {
		logic [2:0][7:0] data;
		logic [1:0]      count;
		logic            last;
	} bundle_t;

	// one character of ";base64" by position
	function automatic logic [7:0] tag_char(input logic [2:0] pos);
		logic [7:0] ch;
		case (pos)
			3'd0: ch = 8'h3b;   // ;
			3'd1: ch = 8'h62;   // b
			3'd2: ch = 8'h61;   // a
			3'd3: ch = 8'h73;   // s
			3'd4: ch = 8'h65;   // e
			3'd5: ch = 8'h36;   // 6
			3'd6: ch = 8'h34;   // 4
			default: ch = 8'h00;
		endcase
		return ch;
	endfunction

	// hex digit value, HEX_NONE when not a hex digit
	function automatic logic [4:0] hex_of(input logic [7:0] c);
		logic [4:0] v;
		v = HEX_NONE;
		if (c >= 8'h30 && c <= 8'h39) v = 5'(c - 8'h30);
		else if (c >= 8'h61 && c <= 8'h66) v = 5'(c - 8'h57);
		else if (c >= 8'h41 && c <= 8'h46) v = 5'(c - 8'h37);
		return v;
	endfunction

	// base64 symbol value, B64_NONE when outside the alphabet
	function automatic logic [6:0] b64_of(input logic [7:0] c);
		logic [6:0] v;
		v = B64_NONE;
		if (c >= 8'h41 && c <= 8'h5a) v = 7'(c - 8'h41);
		else if (c >= 8'h61 && c <= 8'h7a) v = 7'(c - 8'h47);
		else if (c >= 8'h30 && c <= 8'h39) v = 7'(c + 8'h04);
		else if (c == CH_PLUS) v = 7'd62;
		else if (c == CH_SLASH) v = 7'd63;
		return v;
	endfunction

endpackage

`default_nettype wire

/* rtl/data_uri_payload_decoder_unit.sv */
// Data URI payload decoder: takes URI characters one item per clock while the
// bundle queue has room (four bundles deep) and decodes the payload after the
// first comma, as base64 when the metadata holds ";base64", otherwise as
// percent escapes. Each character item is processed in the cycle it is taken;
// the up to three bytes it causes form one bundle, queued only if it holds a
// byte or the end, and leave via a registered output at one result item per
// clock while m_axis_tready is high, so input runs at one item per cycle while
// items average at most one byte, else the output's rate. The last character
// always ends in a result with tlast set; tuser low marks a bare end marker.
`default_nettype none

module data_uri_payload_decoder_unit (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       s_axis_tvalid,
	output logic            s_axis_tready,
	input  wire logic [7:0] s_axis_tdata,   // char_in
	input  wire logic       s_axis_tlast,   // end_of_uri
	output logic            m_axis_tvalid,
	input  wire logic       m_axis_tready,
	output logic [7:0]      m_axis_tdata,   // byte_out
	output logic            m_axis_tuser,   // byte_valid
	output logic            m_axis_tlast    // final_result
);
	import dupd_pkg::*;

	logic    q_full;
	logic    q_push;
	logic    q_pop;
	logic    q_not_empty;
	bundle_t q_in;
	bundle_t q_head;

	// character classification and URI state
	dupd_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (s_axis_tvalid),
		.in_char     (s_axis_tdata),
		.in_last     (s_axis_tlast),
		.q_full      (q_full),
		.in_ready    (s_axis_tready),
		.push        (q_push),
		.push_bundle (q_in)
	);

	// bundle queue
	dupd_queue u_queue (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (q_push),
		.push_bundle (q_in),
		.pop         (q_pop),
		.full        (q_full),
		.not_empty   (q_not_empty),
		.head        (q_head)
	);

	// result sequencing
	dupd_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_not_empty (q_not_empty),
		.q_head      (q_head),
		.q_pop       (q_pop),
		.out_valid   (m_axis_tvalid),
		.out_ready   (m_axis_tready),
		.out_data    (m_axis_tdata),
		.out_user    (m_axis_tuser),
		.out_last    (m_axis_tlast)
	);

endmodule

`default_nettype wire

/* rtl/dupd_front.sv */
// front end: accepts characters, tracks URI state and forms byte bundles
`default_nettype none

module dupd_front (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	input  wire logic [7:0]        in_char,
	input  wire logic              in_last,
	input  wire logic              q_full,
	output logic                   in_ready,
	output logic                   push,
	output dupd_pkg::bundle_t      push_bundle
);
	import dupd_pkg::*;

	typedef enum logic [1:0] {
		PH_META    = 2'd0,
		PH_PAYLOAD = 2'd1,
		PH_STOPPED = 2'd2
	} phase_t;

	phase_t          phase_q, phase_d;
	logic [2:0]      tag_q, tag_d;
	logic            b64_q, b64_d;
	logic [11:0]     acc_q, acc_d;
	logic [2:0]      cnt_q, cnt_d;
	logic [1:0]      pend_q, pend_d;
	logic [1:0][7:0] pchar_q, pchar_d;

	logic            accept;
	logic [2:0][7:0] bytes;
	logic [1:0]      n;
	logic [6:0]      b64v;
	logic [4:0]      hexc;
	logic [4:0]      hexp;
	logic [3:0]      cnt_sum;
	logic            tail;

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;

	// next state and the bytes this item causes
	always_comb begin
		phase_d = phase_q;
		tag_d   = tag_q;
		b64_d   = b64_q;
		acc_d   = acc_q;
		cnt_d   = cnt_q;
		pend_d  = pend_q;
		pchar_d = pchar_q;
		bytes   = '0;
		n       = 2'd0;
		b64v    = b64_of(in_char);
		hexc    = hex_of(in_char);
		hexp    = hex_of(pchar_q[1]);
		cnt_sum = 4'd0;
		tail    = 1'b0;

		case (phase_q)
			PH_META: begin
				if (in_char == CH_COMMA) begin
					phase_d = PH_PAYLOAD;
				end else if (!b64_q) begin
					if (tag_q < TAG_LEN && in_char == tag_char(tag_q))
						tag_d = tag_q + 3'd1;
					else
						tag_d = (in_char == CH_SEMI) ? 3'd1 : 3'd0;
					if (tag_d == TAG_LEN) b64_d = 1'b1;
				end
			end
			PH_PAYLOAD: begin
				if (b64_q) begin
					// base64: six bits in, a byte out once eight are held
					if (in_char == CH_EQUALS) begin
						phase_d = PH_STOPPED;
					end else if (b64v != B64_NONE) begin
						acc_d   = {acc_q[5:0], b64v[5:0]};
						cnt_sum = {1'b0, cnt_q} + 4'd6;
						cnt_d   = cnt_sum[2:0];
						if (cnt_sum >= 4'd8) begin
							cnt_d    = 3'(cnt_sum - 4'd8);
							bytes[n] = 8'(acc_d >> cnt_d);
							n        = n + 2'd1;
						end
					end
				end else begin
					// percent decoding with a held escape
					case (pend_q)
						2'd1: begin
							if (hexc != HEX_NONE) begin
								pchar_d[1] = in_char;
								pend_d     = 2'd2;
							end else begin
								bytes[n] = pchar_q[0];
								n        = n + 2'd1;
								pend_d   = 2'd0;
								tail     = 1'b1;
							end
						end
						2'd2: begin
							if (hexc != HEX_NONE) begin
								bytes[n] = {hexp[3:0], hexc[3:0]};
								n        = n + 2'd1;
								pend_d   = 2'd0;
							end else begin
								bytes[n] = pchar_q[0];
								n        = n + 2'd1;
								bytes[n] = pchar_q[1];
								n        = n + 2'd1;
								pend_d   = 2'd0;
								tail     = 1'b1;
							end
						end
						default: begin
							pend_d = 2'd0;
							tail   = 1'b1;
						end
					endcase
					// the breaking character is processed anew
					if (tail) begin
						if (in_char == CH_PERCENT) begin
							pchar_d[0] = in_char;
							pend_d     = 2'd1;
						end else begin
							bytes[n] = in_char;
							n        = n + 2'd1;
						end
					end
				end
			end
			default: begin
				// decoding stopped by padding, characters ignored
			end
		endcase

		// end of URI: flush a held escape, then back to reset state
		if (in_last) begin
			if (phase_d == PH_PAYLOAD && !b64_d) begin
				if (pend_d >= 2'd1) begin
					bytes[n] = pchar_d[0];
					n        = n + 2'd1;
				end
				if (pend_d >= 2'd2) begin
					bytes[n] = pchar_d[1];
					n        = n + 2'd1;
				end
			end
			phase_d = PH_META;
			tag_d   = 3'd0;
			b64_d   = 1'b0;
			acc_d   = '0;
			cnt_d   = 3'd0;
			pend_d  = 2'd0;
			pchar_d = '0;
		end
	end

	// bundle goes to the queue when it carries bytes or the end
	assign push              = accept && (n != 2'd0 || in_last);
	assign push_bundle.data  = bytes;
	assign push_bundle.count = n;
	assign push_bundle.last  = in_last;

	// URI state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_META;
			tag_q   <= 3'd0;
			b64_q   <= 1'b0;
			acc_q   <= '0;
			cnt_q   <= 3'd0;
			pend_q  <= 2'd0;
			pchar_q <= '0;
		end else if (accept) begin
			phase_q <= phase_d;
			tag_q   <= tag_d;
			b64_q   <= b64_d;
			acc_q   <= acc_d;
			cnt_q   <= cnt_d;
			pend_q  <= pend_d;
			pchar_q <= pchar_d;
		end
	end

endmodule

`default_nettype wire

/* rtl/dupd_queue.sv */
// short bundle queue between the front end and the output sequencer
`default_nettype none

module dupd_queue (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	input  wire dupd_pkg::bundle_t push_bundle,
	input  wire logic              pop,
	output logic                   full,
	output logic                   not_empty,
	output dupd_pkg::bundle_t      head
);
	import dupd_pkg::*;

	bundle_t            mem_q [QDEPTH];
	logic [QPTR_W-1:0]  wr_q;
	logic [QPTR_W-1:0]  rd_q;
	logic [QPTR_W:0]    fill_q;
	logic               do_pop;

	assign full      = (fill_q == (QPTR_W+1)'(QDEPTH));
	assign not_empty = (fill_q != '0);
	assign head      = mem_q[rd_q];
	assign do_pop    = pop && not_empty;

	// storage
	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= push_bundle;
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q   <= '0;
			rd_q   <= '0;
			fill_q <= '0;
		end else begin
			if (push)   wr_q <= wr_q + 1'b1;
			if (do_pop) rd_q <= rd_q + 1'b1;
			case ({push, do_pop})
				2'b10:   fill_q <= fill_q + 1'b1;
				2'b01:   fill_q <= fill_q - 1'b1;
				default: fill_q <= fill_q;
			endcase
		end
	end

endmodule

`default_nettype wire

/* rtl/dupd_back.sv */
// back end: walks each bundle and presents one result item per cycle while the output is ready
`default_nettype none

module dupd_back (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              q_not_empty,
	input  wire dupd_pkg::bundle_t q_head,
	output logic                   q_pop,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output logic [7:0]             out_data,
	output logic                   out_user,
	output logic                   out_last
);
	import dupd_pkg::*;

	logic [1:0] idx_q;
	logic       valid_q;
	logic [7:0] data_q;
	logic       user_q;
	logic       last_q;
	logic       load;
	logic       bare;
	logic       at_end;

	assign load   = !valid_q || out_ready;
	assign bare   = (q_head.count == 2'd0);
	assign at_end = bare || (idx_q == q_head.count - 2'd1);
	assign q_pop  = load && q_not_empty && at_end;

	// output register and position within the head bundle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= 2'd0;
			valid_q <= 1'b0;
			data_q  <= 8'd0;
			user_q  <= 1'b0;
			last_q  <= 1'b0;
		end else if (load) begin
			valid_q <= q_not_empty;
			if (q_not_empty) begin
				data_q <= bare ? 8'd0 : q_head.data[idx_q];
				user_q <= !bare;
				last_q <= q_head.last && at_end;
				idx_q  <= at_end ? 2'd0 : idx_q + 2'd1;
			end
		end
	end

	assign out_valid = valid_q;
	assign out_data  = data_q;
	assign out_user  = user_q;
	assign out_last  = last_q;

endmodule

`default_nettype wire
